@@ hw/rtl/dprc_pkg.sv @@
// Package for the dual-polarisation reflectivity correction block.
// Holds the register indexes, outcome codes, shared word types and saturation.
// No dependencies.
package dprc_pkg;

   localparam int CodeWidth     = 16;
   localparam int DataWidth     = 32;
   localparam int CsrIndexWidth = 3;
   localparam int SquareSteps   = 24;
   localparam int QuotBits      = 17;
   localparam int LogLatency    = SquareSteps + 3;

   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_GAIN   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_OFFSET = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ZDR_GAIN      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ZDR_OFFSET    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_RHOHV_GAIN    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_RHOHV_OFFSET  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_SIGNED_RAW    = 3'd6;

   localparam logic signed [DataWidth-1:0] GainOne = 32'sh0100_0000;
   localparam logic signed [33:0] Log10Scaled = 34'sd3232284966;

   typedef enum logic [2:0] {
      OUT_INVALID  = 3'd0,
      OUT_KEPT     = 3'd1,
      OUT_INTEGRAL = 3'd2,
      OUT_SCALED   = 3'd3,
      OUT_CLIPPED  = 3'd4
   } outcome_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] target_gain;
      logic signed [DataWidth-1:0] target_offset;
      logic signed [DataWidth-1:0] zdr_gain;
      logic signed [DataWidth-1:0] zdr_offset;
      logic signed [DataWidth-1:0] rhohv_gain;
      logic signed [DataWidth-1:0] rhohv_offset;
      logic                        signed_raw;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 done;
      outcome_type          outcome;
      logic [CodeWidth-1:0] code;
   } gate_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

@@ hw/rtl/dprc_scale.sv @@
// Two-stage scaling of one raw code to a Q16.16 physical value.
// Depends on dprc_pkg for the saturation function.
module dprc_scale (
   input  logic               clock,
   input  logic [15:0]        code,
   input  logic               signed_raw,
   input  logic signed [31:0] gain,
   input  logic signed [31:0] offset,
   output logic signed [31:0] phys
);
   import dprc_pkg::*;

   logic signed [16:0] raw;
   logic signed [48:0] prod_in, prod_ff;
   logic signed [49:0] acc;
   logic signed [41:0] shifted;
   logic signed [31:0] phys_in, phys_ff;

   assign raw     = $signed({signed_raw & code[15], code});
   assign prod_in = 49'(raw) * 49'(gain);
   assign acc     = 50'(prod_ff) + (50'(offset) <<< 8) + 50'sd128;
   assign shifted = 42'(acc >>> 8);
   assign phys_in = sat32(64'(shifted));
   assign phys    = phys_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      phys_ff <= phys_in;
   end

endmodule

@@ hw/rtl/dprc_log.sv @@
// Pipelined 10*log10 of a positive Q16.16 value by repeated squaring.
// One squaring per stage; depends on dprc_pkg for the stage count and constant.
module dprc_log (
   input  logic               clock,
   input  logic signed [31:0] value,
   output logic signed [31:0] db
);
   import dprc_pkg::*;

   logic [30:0] x;
   logic [4:0]  exp_in;
   logic [30:0] norm_in;
   logic [30:0] m_ff    [0:SquareSteps];
   logic [23:0] frac_ff [0:SquareSteps];
   logic [4:0]  exp_ff  [0:SquareSteps];
   logic signed [5:0]  exp_bias;
   logic signed [29:0] lg;
   logic signed [63:0] p_in, p_ff;
   logic signed [31:0] db_in, db_ff;

   assign x = value[30:0];

   always_comb begin
      exp_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (x[i]) begin
            exp_in = 5'(i);
         end
      end
      norm_in = 31'(x << (5'd30 - exp_in));
   end

   always_ff @(posedge clock) begin
      m_ff[0]    <= norm_in;
      frac_ff[0] <= '0;
      exp_ff[0]  <= exp_in;
   end

   for (genvar s = 0; s < SquareSteps; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] n;
      logic [30:0] m_in;
      logic [23:0] frac_in;

      assign sq      = 62'(m_ff[s]) * 62'(m_ff[s]);
      assign n       = sq[61:30];
      assign m_in    = n[31] ? n[31:1] : n[30:0];
      assign frac_in = {frac_ff[s][22:0], n[31]};

      always_ff @(posedge clock) begin
         m_ff[s+1]    <= m_in;
         frac_ff[s+1] <= frac_in;
         exp_ff[s+1]  <= exp_ff[s];
      end
   end

   assign exp_bias = $signed({1'b0, exp_ff[SquareSteps]}) - 6'sd16;
   assign lg       = $signed({exp_bias, frac_ff[SquareSteps]});
   assign p_in     = 64'(lg) * 64'(Log10Scaled);
   assign db_in    = 32'((p_ff + 64'sd137438953472) >>> 38);
   assign db       = db_ff;

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      db_ff <= db_in;
   end

endmodule

@@ hw/rtl/dprc_div.sv @@
// Return to a raw code: integral test, zero-gain keep, pipelined restoring division with
// round half to even, and clipping. Depends on dprc_pkg.
module dprc_div (
   input  logic               clock,
   input  logic               reset,
   input  dprc_pkg::cfg_type  cfg,
   input  dprc_pkg::gate_type gate_in,
   input  logic signed [31:0] pc,
   output dprc_pkg::gate_type gate_out
);
   import dprc_pkg::*;

   logic signed [15:0] ipart;
   logic               in_range;
   logic signed [32:0] diff;
   logic signed [40:0] num;
   logic signed [41:0] n;
   logic [41:0]        na;
   logic               den_neg, neg_in;
   logic [31:0]        den_in;
   logic               big;
   logic [15:0]        rmin_code, rmax_code;
   gate_type           prep_in;

   logic [31:0]        rem_ff  [0:QuotBits];
   logic [16:0]        lo_ff   [0:QuotBits];
   logic [16:0]        quo_ff  [0:QuotBits];
   logic [31:0]        den_ff  [0:QuotBits];
   logic               neg_ff  [0:QuotBits];
   gate_type           gate_ff [0:QuotBits];

   logic [16:0]        qa;
   logic [31:0]        ra;
   logic signed [18:0] q_in, q_ff;
   logic [31:0]        r_in, r_ff, dfin_ff;
   gate_type           fin_ff;
   logic               up;
   logic signed [18:0] qr, rmin_s, rmax_s;
   gate_type           out_in, out_ff;

   assign rmin_code = cfg.signed_raw ? 16'h8000 : 16'h0000;
   assign rmax_code = cfg.signed_raw ? 16'h7fff : 16'hffff;
   assign rmin_s    = cfg.signed_raw ? -19'sd32768 : 19'sd0;
   assign rmax_s    = cfg.signed_raw ? 19'sd32767 : 19'sd65535;

   always_comb begin
      ipart    = pc[31:16];
      in_range = cfg.signed_raw || !ipart[15];
      diff     = 33'(pc) - 33'(cfg.target_offset);
      num      = 41'(diff) <<< 8;
      den_neg  = cfg.target_gain[31];
      den_in   = den_neg ? 32'(-cfg.target_gain) : 32'(cfg.target_gain);
      n        = den_neg ? -42'(num) : 42'(num);
      neg_in   = n[41];
      na       = neg_in ? 42'(-n) : 42'(n);
      big      = {7'b0, na[41:17]} >= den_in;
      prep_in  = gate_in;
      if (!gate_in.done) begin
         if (pc[15:0] == 16'd0 && in_range) begin
            prep_in.done    = 1'b1;
            prep_in.outcome = OUT_INTEGRAL;
            prep_in.code    = ipart;
         end else if (cfg.target_gain == 32'sd0) begin
            prep_in.done    = 1'b1;
            prep_in.outcome = OUT_KEPT;
         end else if (big) begin
            prep_in.done    = 1'b1;
            prep_in.outcome = OUT_CLIPPED;
            prep_in.code    = neg_in ? rmin_code : rmax_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff[0] <= '0;
      end else begin
         gate_ff[0] <= prep_in;
      end
      rem_ff[0] <= {7'b0, na[41:17]};
      lo_ff[0]  <= na[16:0];
      quo_ff[0] <= '0;
      den_ff[0] <= den_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar k = 0; k < QuotBits; k++) begin : g_div
      logic [32:0] trial;
      logic        ge;
      logic [31:0] rem_in;

      assign trial  = {rem_ff[k], lo_ff[k][16]};
      assign ge     = trial >= {1'b0, den_ff[k]};
      assign rem_in = ge ? 32'(trial - {1'b0, den_ff[k]}) : trial[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            gate_ff[k+1] <= '0;
         end else begin
            gate_ff[k+1] <= gate_ff[k];
         end
         rem_ff[k+1] <= rem_in;
         lo_ff[k+1]  <= {lo_ff[k][15:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][15:0], ge};
         den_ff[k+1] <= den_ff[k];
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   always_comb begin
      qa = quo_ff[QuotBits];
      ra = rem_ff[QuotBits];
      if (!neg_ff[QuotBits]) begin
         q_in = $signed({2'b00, qa});
         r_in = ra;
      end else if (ra == 32'd0) begin
         q_in = -$signed({2'b00, qa});
         r_in = '0;
      end else begin
         q_in = -$signed({2'b00, qa}) - 19'sd1;
         r_in = den_ff[QuotBits] - ra;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= '0;
      end else begin
         fin_ff <= gate_ff[QuotBits];
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      dfin_ff <= den_ff[QuotBits];
   end

   always_comb begin
      up     = ({r_ff, 1'b0} > {1'b0, dfin_ff}) ||
               ({r_ff, 1'b0} == {1'b0, dfin_ff} && q_ff[0]);
      qr     = q_ff + $signed({18'd0, up});
      out_in = fin_ff;
      if (!fin_ff.done) begin
         out_in.done = 1'b1;
         if (qr < rmin_s) begin
            out_in.outcome = OUT_CLIPPED;
            out_in.code    = rmin_code;
         end else if (qr > rmax_s) begin
            out_in.outcome = OUT_CLIPPED;
            out_in.code    = rmax_code;
         end else begin
            out_in.outcome = OUT_SCALED;
            out_in.code    = qr[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign gate_out = out_ff;

   // The partial remainder of a restoring division never reaches the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      gate_ff[QuotBits].valid && !gate_ff[QuotBits].done |->
      rem_ff[QuotBits] < den_ff[QuotBits])
      else $error("division remainder not below divisor");

endmodule

@@ hw/rtl/dualpol_reflectivity_correction.sv @@
// Dual-polarisation reflectivity correction, one gate word per clock cycle.
// A result word passes the two scaling stages, the 24 squaring and three other stages of
// the logarithm, the sum stage and the 20 stages of the divider before it is strobed.
// Throughput: one gate word per cycle; busy is always low and nothing stalls.
// Reset clears all valid bits and returns the registers to unity gain, zero offset.
module dualpol_reflectivity_correction (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_target_code,
   input  logic [15:0] req_zdr_code,
   input  logic [15:0] req_rhohv_code,
   output logic        rsp_valid,
   output logic [15:0] rsp_corrected_code,
   output logic [2:0]  rsp_outcome,
   input  logic        csr_write_enable,
   input  logic [dprc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [dprc_pkg::DataWidth-1:0]     csr_data
);
   import dprc_pkg::*;

   typedef struct packed {
      gate_type           gate;
      logic signed [31:0] pt;
      logic signed [31:0] pz;
   } carry_type;

   cfg_type            cfg_ff;
   gate_type           entry_in, s1_ff, s2_ff, log_in, pc_gate_ff, result;
   logic signed [31:0] pt, pz, pr, db;
   carry_type          dly_ff [0:LogLatency-1];
   logic signed [34:0] sum;
   logic signed [31:0] pc_in, pc_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_gain   <= GainOne;
         cfg_ff.target_offset <= '0;
         cfg_ff.zdr_gain      <= GainOne;
         cfg_ff.zdr_offset    <= '0;
         cfg_ff.rhohv_gain    <= GainOne;
         cfg_ff.rhohv_offset  <= '0;
         cfg_ff.signed_raw    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_GAIN:   cfg_ff.target_gain   <= csr_data;
            CSR_TARGET_OFFSET: cfg_ff.target_offset <= csr_data;
            CSR_ZDR_GAIN:      cfg_ff.zdr_gain      <= csr_data;
            CSR_ZDR_OFFSET:    cfg_ff.zdr_offset    <= csr_data;
            CSR_RHOHV_GAIN:    cfg_ff.rhohv_gain    <= csr_data;
            CSR_RHOHV_OFFSET:  cfg_ff.rhohv_offset  <= csr_data;
            CSR_SIGNED_RAW:    cfg_ff.signed_raw    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      entry_in.valid   = start && !busy;
      entry_in.done    = 1'b0;
      entry_in.outcome = OUT_KEPT;
      entry_in.code    = req_target_code;
      if (req_target_code == 16'd0) begin
         entry_in.done    = 1'b1;
         entry_in.outcome = OUT_INVALID;
      end else if (req_zdr_code == 16'd0 || req_rhohv_code == 16'd0) begin
         entry_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= entry_in;
         s2_ff <= s1_ff;
      end
   end

   dprc_scale u_scale_target (
      .clock      (clock),
      .code       (req_target_code),
      .signed_raw (cfg_ff.signed_raw),
      .gain       (cfg_ff.target_gain),
      .offset     (cfg_ff.target_offset),
      .phys       (pt)
   );

   dprc_scale u_scale_zdr (
      .clock      (clock),
      .code       (req_zdr_code),
      .signed_raw (cfg_ff.signed_raw),
      .gain       (cfg_ff.zdr_gain),
      .offset     (cfg_ff.zdr_offset),
      .phys       (pz)
   );

   dprc_scale u_scale_rhohv (
      .clock      (clock),
      .code       (req_rhohv_code),
      .signed_raw (cfg_ff.signed_raw),
      .gain       (cfg_ff.rhohv_gain),
      .offset     (cfg_ff.rhohv_offset),
      .phys       (pr)
   );

   always_comb begin
      log_in = s2_ff;
      if (!s2_ff.done && pr <= 32'sd0) begin
         log_in.done = 1'b1;
      end
   end

   dprc_log u_log (
      .clock (clock),
      .value (pr),
      .db    (db)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff[0].gate <= '0;
      end else begin
         dly_ff[0].gate <= log_in;
      end
      dly_ff[0].pt <= pt;
      dly_ff[0].pz <= pz;
      for (int i = 1; i < LogLatency; i++) begin
         if (reset) begin
            dly_ff[i].gate <= '0;
         end else begin
            dly_ff[i].gate <= dly_ff[i-1].gate;
         end
         dly_ff[i].pt <= dly_ff[i-1].pt;
         dly_ff[i].pz <= dly_ff[i-1].pz;
      end
   end

   assign sum   = (35'(dly_ff[LogLatency-1].pt) <<< 1) + 35'(dly_ff[LogLatency-1].pz)
                  - (35'(db) <<< 1);
   assign pc_in = sat32(64'(sum >>> 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_gate_ff <= '0;
      end else begin
         pc_gate_ff <= dly_ff[LogLatency-1].gate;
      end
      pc_ff <= pc_in;
   end

   dprc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .gate_in  (pc_gate_ff),
      .pc       (pc_ff),
      .gate_out (result)
   );

   assign rsp_valid          = result.valid;
   assign rsp_corrected_code = result.code;
   assign rsp_outcome        = result.outcome;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_INVALID |-> rsp_corrected_code == 16'd0)
      else $error("invalid target word without a zero code");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_CLIPPED |->
      (cfg_ff.signed_raw && (rsp_corrected_code == 16'h8000 ||
                             rsp_corrected_code == 16'h7fff)) ||
      (!cfg_ff.signed_raw && (rsp_corrected_code == 16'h0000 ||
                              rsp_corrected_code == 16'hffff)))
      else $error("clipped word not at a range bound");

endmodule
